>>> hw/rtl/pswd_pkg.sv
// Shared types, constants and helper functions of the PNG stored-deflate writer.
`timescale 1ns / 1ps

package pswd_pkg;

	localparam int unsigned SIDE_W       = 14;
	localparam int unsigned MAX_SIDE     = 8192;
	localparam int unsigned COL_W        = 15;   // holds 3 * MAX_SIDE
	localparam int unsigned ROW_W        = 13;   // holds MAX_SIDE - 1
	localparam int unsigned RAW_W        = 28;   // raw zlib payload byte count
	localparam int unsigned BLOCKS_W     = 13;
	localparam int unsigned IDX_W        = 6;
	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned CFG_ADDR_W   = 3;

	// Stored block payload limit; the block count math relies on 2^16 - 1.
	localparam int unsigned BLOCK_CAP    = 65535;
	localparam int unsigned ADLER_MOD    = 65521;
	// zlib header (2) plus Adler-32 trailer (4)
	localparam int unsigned IDAT_FIXED   = 6;

	localparam logic [31:0] CRC_POLY     = 32'hedb88320;
	localparam logic [31:0] CRC_INIT     = 32'hffffffff;

	// register index decoded from paddr[2]
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0]        sample;
		logic              first;      // opens a new file
		logic              row_start;  // needs a filter byte in front
		logic              last;       // closes the file
		logic [SIDE_W-1:0] img_w;
		logic [SIDE_W-1:0] img_h;
	} item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_HDR,
		BK_BLK,
		BK_RAW,
		BK_TRL
	} back_state_t;

	function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (v > SIDE_W'(MAX_SIDE)) begin
			r = SIDE_W'(MAX_SIDE);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'h000000, data};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/png_stored_deflate_writer_core.sv
// Top level of the PNG stored-deflate writer: register port, front end, queue and sequencer.
`timescale 1ns / 1ps

// Turns a raster stream of 8-bit RGB sample bytes into a complete PNG file.
// Input channel (in_valid / in_stall / sample_byte): one component byte per word,
// R,G,B per pixel, top row first. Output channel (out_valid / out_stall) carries
// file_byte with run_end on the last byte caused by an input word and file_end on
// the final IEND byte. image_width (0x0) and image_height (0x4) are set over the
// register port between files; writes while an image is in progress are dropped,
// and zero or oversized values are clamped to 1 and 8192.
// Timing: a word is accepted each cycle while the four-entry queue has room. The
// sequencer emits one byte per cycle unless stalled: 43 header bytes before the first
// image byte, then one byte per sample, one filter byte per row, 5 header bytes per
// stored block of up to 65535 raw bytes, and 20 trailer bytes after the last sample.
// A word for an idle sequencer is registered in queue, sequencer and output in turn.
// When the receiver stalls, the output word holds and the queue absorbs up to four
// input words before in_stall rises. Reset empties the queue, drops any partial
// file and sets both size registers to 1; the next word starts a new file.

module png_stored_deflate_writer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pswd_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      sample_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      file_byte,
	output logic                            run_end,
	output logic                            file_end
);

	logic [pswd_pkg::SIDE_W-1:0] width_q;
	logic [pswd_pkg::SIDE_W-1:0] height_q;
	logic                        busy;
	logic                        cfg_wr;

	logic                        q_full;
	logic                        q_push;
	pswd_pkg::item_t             q_in;
	logic                        q_valid;
	logic                        q_pop;
	pswd_pkg::item_t             q_out;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			pswd_pkg::REG_IMAGE_WIDTH:  prdata = {18'h00000, width_q};
			pswd_pkg::REG_IMAGE_HEIGHT: prdata = {18'h00000, height_q};
			default:                    prdata = 32'h00000000;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pswd_pkg::SIDE_W'(1);
			height_q <= pswd_pkg::SIDE_W'(1);
		end else if (cfg_wr && !busy) begin
			case (paddr[2])
				pswd_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[pswd_pkg::SIDE_W-1:0];
				pswd_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[pswd_pkg::SIDE_W-1:0];
				default:                    width_q  <= width_q;
			endcase
		end
	end

	pswd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.sample_byte (sample_byte),
		.in_stall    (in_stall),
		.cfg_w       (width_q),
		.cfg_h       (height_q),
		.busy        (busy),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_in)
	);

	pswd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.item      (q_out)
	);

	pswd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_out),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.file_byte (file_byte),
		.run_end   (run_end),
		.file_end  (file_end)
	);

	// sequencer never pulls from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// image size is frozen while a file is in progress
	a_size_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && busy) |=> ($stable(width_q) && $stable(height_q)))
		else $error("size register changed during an image");

	// the IEND byte always closes the run of its input word
	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && file_end) |-> run_end)
		else $error("file_end without run_end");

endmodule

>>> hw/rtl/pswd_front.sv
// Front end: accepts sample bytes and tags them with file, row and end-of-file marks.
`timescale 1ns / 1ps

module pswd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [7:0]                    sample_byte,
	output logic                          in_stall,
	input  logic [pswd_pkg::SIDE_W-1:0]   cfg_w,
	input  logic [pswd_pkg::SIDE_W-1:0]   cfg_h,
	output logic                          busy,
	input  logic                          q_full,
	output logic                          q_push,
	output pswd_pkg::item_t               q_item
);

	logic [pswd_pkg::COL_W-1:0]  col_q;
	logic [pswd_pkg::ROW_W-1:0]  row_q;
	logic                        busy_q;

	logic [pswd_pkg::SIDE_W-1:0] w_eff;
	logic [pswd_pkg::SIDE_W-1:0] h_eff;
	logic [pswd_pkg::SIDE_W-1:0] h_m1;
	logic [pswd_pkg::COL_W-1:0]  row_len;
	logic                        end_col;
	logic                        last_byte;

	// size registers cannot change while busy, so no latching is needed here
	assign w_eff     = pswd_pkg::eff_side(cfg_w);
	assign h_eff     = pswd_pkg::eff_side(cfg_h);
	assign h_m1      = h_eff - pswd_pkg::SIDE_W'(1);
	assign row_len   = ({1'b0, w_eff} << 1) + {1'b0, w_eff};
	assign end_col   = (col_q == row_len - pswd_pkg::COL_W'(1));
	assign last_byte = end_col && (row_q == h_m1[pswd_pkg::ROW_W-1:0]);

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign busy     = busy_q;

	always_comb begin
		q_item.sample    = sample_byte;
		q_item.first     = !busy_q;
		q_item.row_start = (col_q == '0);
		q_item.last      = last_byte;
		q_item.img_w     = w_eff;
		q_item.img_h     = h_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			busy_q <= 1'b0;
		end else if (q_push) begin
			if (last_byte) begin
				col_q  <= '0;
				row_q  <= '0;
				busy_q <= 1'b0;
			end else begin
				busy_q <= 1'b1;
				if (end_col) begin
					col_q <= '0;
					row_q <= row_q + pswd_pkg::ROW_W'(1);
				end else begin
					col_q <= col_q + pswd_pkg::COL_W'(1);
				end
			end
		end
	end

endmodule

>>> hw/rtl/pswd_queue.sv
// Short word queue between the front end and the stream sequencer.
`timescale 1ns / 1ps

module pswd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pswd_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output pswd_pkg::item_t item
);

	pswd_pkg::item_t             slot_q [pswd_pkg::QUEUE_DEPTH];
	logic [pswd_pkg::QPTR_W-1:0] wr_q;
	logic [pswd_pkg::QPTR_W-1:0] rd_q;
	logic [pswd_pkg::QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == pswd_pkg::QCNT_W'(pswd_pkg::QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign item  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == pswd_pkg::QPTR_W'(pswd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_q + pswd_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == pswd_pkg::QPTR_W'(pswd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_q + pswd_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + pswd_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - pswd_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/pswd_back.sv
// Stream sequencer: emits PNG headers, stored blocks, checksums and IEND a byte at a time.
`timescale 1ns / 1ps

module pswd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  pswd_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      file_byte,
	output logic            run_end,
	output logic            file_end
);

	localparam logic [pswd_pkg::IDX_W-1:0] HDR_IHDR_TAG = 6'd12;
	localparam logic [pswd_pkg::IDX_W-1:0] HDR_IHDR_END = 6'd28;
	localparam logic [pswd_pkg::IDX_W-1:0] HDR_IDAT_TAG = 6'd37;
	localparam logic [pswd_pkg::IDX_W-1:0] HDR_LAST     = 6'd42;
	localparam logic [pswd_pkg::IDX_W-1:0] BLK_LAST     = 6'd4;
	localparam logic [pswd_pkg::IDX_W-1:0] TRL_ADLER_END = 6'd3;
	localparam logic [pswd_pkg::IDX_W-1:0] TRL_IEND_TAG = 6'd12;
	localparam logic [pswd_pkg::IDX_W-1:0] TRL_IEND_END = 6'd15;
	localparam logic [pswd_pkg::IDX_W-1:0] TRL_LAST     = 6'd19;

	pswd_pkg::back_state_t       st_q, st_nx;
	logic [pswd_pkg::IDX_W-1:0]  idx_q, idx_nx;

	logic [7:0]                  cur_byte_q;
	logic                        filt_q, filt_nx;
	logic                        last_q;
	logic [pswd_pkg::SIDE_W-1:0] w_q;
	logic [pswd_pkg::SIDE_W-1:0] h_q;
	logic [pswd_pkg::RAW_W-1:0]  raw_left_q, raw_left_d;
	logic [15:0]                 block_left_q, block_left_d;
	logic [15:0]                 adler_lo_q, adler_hi_q;
	logic [31:0]                 crc_q;

	logic [pswd_pkg::RAW_W-1:0]    raw_s1;
	logic [pswd_pkg::BLOCKS_W-1:0] blocks_s2;
	logic [31:0]                   idat_s3;

	logic                        ovalid_q;
	logic [7:0]                  obyte_q;
	logic                        orun_q;
	logic                        oend_q;

	logic                        can_go;
	logic                        emit;
	logic                        step;
	logic                        item_done;
	logic [7:0]                  obyte_d;
	logic                        crc_en;
	logic                        crc_rst;
	logic                        raw_en;
	logic                        adler_rst;
	logic                        run_d;
	logic                        end_d;
	pswd_pkg::back_state_t       st_d;
	logic [pswd_pkg::IDX_W-1:0]  idx_d;
	logic                        filt_d;

	logic [15:0]                 blk_n;
	logic                        blk_final;
	logic [31:0]                 crc_base;
	logic [31:0]                 crc_nx;
	logic [31:0]                 crc_out;
	logic [16:0]                 lo_sum, hi_sum;
	logic [15:0]                 lo_nx, hi_nx;
	logic [7:0]                  hdr_b;
	logic [7:0]                  trl_b;

	logic [pswd_pkg::COL_W-1:0]  w3p1;
	logic [28:0]                 prod;
	logic [28:0]                 blk_x;
	logic [pswd_pkg::BLOCKS_W-1:0] blk_q0;
	logic [16:0]                 blk_r;

	// IDAT length: raw bytes, 5 per each of ceil(raw / 65535) blocks, fixed overhead.
	// Ready long before the length field goes out (header position 33).
	assign w3p1  = ({1'b0, w_q} << 1) + {1'b0, w_q} + pswd_pkg::COL_W'(1);
	assign prod  = h_q * w3p1;
	assign blk_x = {1'b0, raw_s1} + 29'(pswd_pkg::BLOCK_CAP - 1);
	assign blk_q0 = blk_x[28:16];
	// x = q0 * 65535 + (q0 + low half); the remainder term stays below 2 * 65535
	assign blk_r = {1'b0, blk_x[15:0]} + {4'h0, blk_q0};

	always_ff @(posedge clk) begin
		raw_s1    <= prod[pswd_pkg::RAW_W-1:0];
		blocks_s2 <= blk_q0 + ((blk_r >= 17'(pswd_pkg::BLOCK_CAP)) ?
			pswd_pkg::BLOCKS_W'(1) : pswd_pkg::BLOCKS_W'(0));
		idat_s3   <= ({19'h0, blocks_s2} << 2) + {19'h0, blocks_s2} + {4'h0, raw_s1}
			+ 32'(pswd_pkg::IDAT_FIXED);
	end

	// stored block header fields
	assign blk_final = (raw_left_q <= pswd_pkg::RAW_W'(pswd_pkg::BLOCK_CAP));
	assign blk_n     = blk_final ? raw_left_q[15:0] : 16'(pswd_pkg::BLOCK_CAP);
	assign crc_out   = ~crc_q;

	always_comb begin
		case (idx_q)
			6'd0:    hdr_b = 8'd137;
			6'd1:    hdr_b = 8'd80;
			6'd2:    hdr_b = 8'd78;
			6'd3:    hdr_b = 8'd71;
			6'd4:    hdr_b = 8'd13;
			6'd5:    hdr_b = 8'd10;
			6'd6:    hdr_b = 8'd26;
			6'd7:    hdr_b = 8'd10;
			6'd11:   hdr_b = 8'd13;           // IHDR length
			6'd12:   hdr_b = 8'h49;           // I
			6'd13:   hdr_b = 8'h48;           // H
			6'd14:   hdr_b = 8'h44;           // D
			6'd15:   hdr_b = 8'h52;           // R
			6'd18:   hdr_b = {2'b00, w_q[13:8]};
			6'd19:   hdr_b = w_q[7:0];
			6'd22:   hdr_b = {2'b00, h_q[13:8]};
			6'd23:   hdr_b = h_q[7:0];
			6'd24:   hdr_b = 8'd8;            // bit depth
			6'd25:   hdr_b = 8'd2;            // truecolor
			6'd29:   hdr_b = crc_out[31:24];
			6'd30:   hdr_b = crc_out[23:16];
			6'd31:   hdr_b = crc_out[15:8];
			6'd32:   hdr_b = crc_out[7:0];
			6'd33:   hdr_b = idat_s3[31:24];
			6'd34:   hdr_b = idat_s3[23:16];
			6'd35:   hdr_b = idat_s3[15:8];
			6'd36:   hdr_b = idat_s3[7:0];
			6'd37:   hdr_b = 8'h49;           // I
			6'd38:   hdr_b = 8'h44;           // D
			6'd39:   hdr_b = 8'h41;           // A
			6'd40:   hdr_b = 8'h54;           // T
			6'd41:   hdr_b = 8'h78;           // zlib CMF
			6'd42:   hdr_b = 8'h01;           // zlib FLG
			default: hdr_b = 8'h00;
		endcase
	end

	always_comb begin
		case (idx_q)
			6'd0:    trl_b = adler_hi_q[15:8];
			6'd1:    trl_b = adler_hi_q[7:0];
			6'd2:    trl_b = adler_lo_q[15:8];
			6'd3:    trl_b = adler_lo_q[7:0];
			6'd4:    trl_b = crc_out[31:24];
			6'd5:    trl_b = crc_out[23:16];
			6'd6:    trl_b = crc_out[15:8];
			6'd7:    trl_b = crc_out[7:0];
			6'd12:   trl_b = 8'h49;           // I
			6'd13:   trl_b = 8'h45;           // E
			6'd14:   trl_b = 8'h4e;           // N
			6'd15:   trl_b = 8'h44;           // D
			6'd16:   trl_b = crc_out[31:24];
			6'd17:   trl_b = crc_out[23:16];
			6'd18:   trl_b = crc_out[15:8];
			6'd19:   trl_b = crc_out[7:0];
			default: trl_b = 8'h00;
		endcase
	end

	assign can_go = !ovalid_q || !out_stall;
	assign step   = emit && can_go;

	// next state and outputs
	always_comb begin
		st_d         = st_q;
		idx_d        = idx_q;
		filt_d       = filt_q;
		emit         = 1'b0;
		obyte_d      = 8'h00;
		crc_en       = 1'b0;
		crc_rst      = 1'b0;
		raw_en       = 1'b0;
		adler_rst    = 1'b0;
		item_done    = 1'b0;
		run_d        = 1'b0;
		end_d        = 1'b0;
		raw_left_d   = raw_left_q;
		block_left_d = block_left_q;

		case (st_q)
			pswd_pkg::BK_IDLE: begin
				emit = 1'b0;
			end
			pswd_pkg::BK_HDR: begin
				emit    = 1'b1;
				obyte_d = hdr_b;
				crc_en  = (idx_q >= HDR_IHDR_TAG && idx_q <= HDR_IHDR_END) ||
					(idx_q >= HDR_IDAT_TAG);
				crc_rst = (idx_q == HDR_IHDR_TAG) || (idx_q == HDR_IDAT_TAG);
				if (idx_q == HDR_LAST) begin
					st_d         = pswd_pkg::BK_BLK;
					idx_d        = '0;
					raw_left_d   = raw_s1;
					block_left_d = '0;
					adler_rst    = 1'b1;
				end else begin
					idx_d = idx_q + pswd_pkg::IDX_W'(1);
				end
			end
			pswd_pkg::BK_BLK: begin
				emit   = 1'b1;
				crc_en = 1'b1;
				case (idx_q)
					6'd0:    obyte_d = {7'h00, blk_final};
					6'd1:    obyte_d = blk_n[7:0];
					6'd2:    obyte_d = blk_n[15:8];
					6'd3:    obyte_d = ~blk_n[7:0];
					default: obyte_d = ~blk_n[15:8];
				endcase
				if (idx_q == BLK_LAST) begin
					st_d         = pswd_pkg::BK_RAW;
					idx_d        = '0;
					block_left_d = blk_n;
				end else begin
					idx_d = idx_q + pswd_pkg::IDX_W'(1);
				end
			end
			pswd_pkg::BK_RAW: begin
				emit         = 1'b1;
				crc_en       = 1'b1;
				raw_en       = 1'b1;
				obyte_d      = filt_q ? 8'h00 : cur_byte_q;
				block_left_d = block_left_q - 16'd1;
				raw_left_d   = raw_left_q - pswd_pkg::RAW_W'(1);
				idx_d        = '0;
				if (filt_q) begin
					filt_d = 1'b0;
					st_d   = (block_left_d == '0) ? pswd_pkg::BK_BLK : pswd_pkg::BK_RAW;
				end else if (last_q) begin
					st_d = pswd_pkg::BK_TRL;
				end else begin
					item_done = 1'b1;
					run_d     = 1'b1;
					st_d      = pswd_pkg::BK_IDLE;
				end
			end
			pswd_pkg::BK_TRL: begin
				emit    = 1'b1;
				obyte_d = trl_b;
				crc_en  = (idx_q <= TRL_ADLER_END) ||
					(idx_q >= TRL_IEND_TAG && idx_q <= TRL_IEND_END);
				crc_rst = (idx_q == TRL_IEND_TAG);
				if (idx_q == TRL_LAST) begin
					item_done = 1'b1;
					run_d     = 1'b1;
					end_d     = 1'b1;
					st_d      = pswd_pkg::BK_IDLE;
					idx_d     = '0;
				end else begin
					idx_d = idx_q + pswd_pkg::IDX_W'(1);
				end
			end
			default: begin
				st_d = pswd_pkg::BK_IDLE;
			end
		endcase

		// take the next word as soon as the current one finishes
		q_pop = q_valid && ((st_q == pswd_pkg::BK_IDLE) || (step && item_done));

		if (q_pop) begin
			idx_nx  = '0;
			filt_nx = q_item.row_start;
			if (q_item.first) begin
				st_nx = pswd_pkg::BK_HDR;
			end else if (block_left_d == '0) begin
				st_nx = pswd_pkg::BK_BLK;
			end else begin
				st_nx = pswd_pkg::BK_RAW;
			end
		end else if (step) begin
			st_nx   = st_d;
			idx_nx  = idx_d;
			filt_nx = filt_d;
		end else begin
			st_nx   = st_q;
			idx_nx  = idx_q;
			filt_nx = filt_q;
		end
	end

	assign crc_base = crc_rst ? pswd_pkg::CRC_INIT : crc_q;
	assign crc_nx   = pswd_pkg::crc32_byte(crc_base, obyte_d);

	assign lo_sum = {1'b0, adler_lo_q} + {9'h000, obyte_d};
	assign lo_nx  = (lo_sum >= 17'(pswd_pkg::ADLER_MOD)) ?
		16'(lo_sum - 17'(pswd_pkg::ADLER_MOD)) : lo_sum[15:0];
	assign hi_sum = {1'b0, adler_hi_q} + {1'b0, lo_nx};
	assign hi_nx  = (hi_sum >= 17'(pswd_pkg::ADLER_MOD)) ?
		16'(hi_sum - 17'(pswd_pkg::ADLER_MOD)) : hi_sum[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= pswd_pkg::BK_IDLE;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			st_q  <= st_nx;
			idx_q <= idx_nx;
			if (can_go) begin
				ovalid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		filt_q <= filt_nx;
		if (q_pop) begin
			cur_byte_q <= q_item.sample;
			last_q     <= q_item.last;
			if (q_item.first) begin
				w_q <= q_item.img_w;
				h_q <= q_item.img_h;
			end
		end
		if (step) begin
			obyte_q      <= obyte_d;
			orun_q       <= run_d;
			oend_q       <= end_d;
			raw_left_q   <= raw_left_d;
			block_left_q <= block_left_d;
			if (crc_en) begin
				crc_q <= crc_nx;
			end
			if (adler_rst) begin
				adler_lo_q <= 16'd1;
				adler_hi_q <= 16'd0;
			end else if (raw_en) begin
				adler_lo_q <= lo_nx;
				adler_hi_q <= hi_nx;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign file_byte = obyte_q;
	assign run_end   = orun_q;
	assign file_end  = oend_q;

endmodule
